>>> rtl/oss_pkg.sv
// Package for the on/off segment sequencer.
// Holds item codes, field widths and the table entry type; depends on nothing.
package oss_pkg;

  // Field widths of the item channels.
  localparam int MODE_W   = 2;
  localparam int TIME_W   = 32;
  localparam int SLOT_W   = 4;
  localparam int MIN_W    = 16;
  localparam int ACTION_W = 2;
  localparam int SEGNUM_W = 4;

  // Configuration port widths.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  // Internal widths: segment index, effective count and pass count.
  localparam int IDX_W   = 5;
  localparam int COUNT_W = 7;
  localparam int PASS_W  = 8;

  // One minute in milliseconds.
  localparam logic [TIME_W-1:0] MS_PER_MINUTE = 32'd60000;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_SEGMENT_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_ENABLE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_LIMIT  = 2'd2;

  // Input item modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 2'd0,
    MODE_RESTART = 2'd1,
    MODE_WRITE   = 2'd2,
    MODE_IGNORE  = 2'd3
  } mode_t;

  // Result actions.
  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE = 2'd0,
    ACT_ON   = 2'd1,
    ACT_OFF  = 2'd2,
    ACT_STOP = 2'd3
  } action_t;

  // One table entry, kept already scaled to milliseconds.
  typedef struct packed {
    logic [TIME_W-1:0] on_ms;
    logic [TIME_W-1:0] off_ms;
  } seg_entry_t;

endpackage

>>> rtl/oss_if.sv
// Channel interfaces of the on/off segment sequencer: command, result, configuration.
// Depends on oss_pkg for the field widths.
interface oss_in_if import oss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [TIME_W-1:0] now_ms;
  logic [SLOT_W-1:0] slot;
  logic [MIN_W-1:0]  on_minutes;
  logic [MIN_W-1:0]  off_minutes;

  modport source (output valid, mode, now_ms, slot, on_minutes, off_minutes, input ready);
  modport sink (input valid, mode, now_ms, slot, on_minutes, off_minutes, output ready);
endinterface

interface oss_out_if import oss_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SEGNUM_W-1:0] segment_number;
  logic                running;

  modport source (output valid, action, segment_number, running, input ready);
  modport sink (input valid, action, segment_number, running, output ready);
endinterface

interface oss_cfg_if import oss_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/oss_seg_mem.sv
// Segment table memory: one write port, one registered read port, write-to-read forwarding.
// Depends on oss_pkg for the entry type.
module oss_seg_mem import oss_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  seg_entry_t    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output seg_entry_t    rd_data
);

  seg_entry_t mem [DEPTH];
  seg_entry_t rd_q;
  seg_entry_t fwd_data;
  logic       fwd_hit;

  // Storage array with a synchronous read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  // A read that collides with a write in the same cycle takes the new entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit ? fwd_data : rd_q;

endmodule

>>> rtl/on_off_segment_sequencer.sv
// On/off segment sequencer top level.
// A result comes from the step stage: the table is read at the edge that accepts an item, and
// the step is registered into the output register once the step stage advances.
// Throughput: one item per cycle unless the result channel stalls; the table read for the next
// item overlaps the step of the current one, with forwarding from a table write in the same cycle.
// Reset clears the configuration and run state; table entries are undefined until written.
module on_off_segment_sequencer import oss_pkg::*; #(
  parameter int MAX_SEGMENTS = 16
) (
  input logic       clk,
  input logic       rst,
  oss_in_if.sink    cmd,
  oss_out_if.source result,
  oss_cfg_if.sink   cfg
);

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  // Configuration registers.
  logic [4:0]        segment_count;
  logic              repeat_enable;
  logic [PASS_W-1:0] repeat_limit;

  // Run state.
  logic              started, started_next;
  logic [IDX_W-1:0]  cur_idx, cur_idx_next;
  logic              in_on, in_on_next;
  logic [TIME_W-1:0] start_ms, start_ms_next;
  logic [PASS_W-1:0] pass_cnt, pass_cnt_next;

  // Step stage registers.
  logic              s1_valid;
  mode_t             s1_mode;
  logic [TIME_W-1:0] s1_now;
  logic [SLOT_W-1:0] s1_slot;
  seg_entry_t        s1_wr_entry;

  // Output register.
  logic                out_valid;
  action_t             out_action;
  logic [SEGNUM_W-1:0] out_seg;
  logic                out_run;

  logic       accept;
  logic       s1_adv;
  seg_entry_t in_entry;
  seg_entry_t entry;
  logic       wr_en;
  logic [7:0] slot8;
  logic [7:0] rd_idx8;
  logic [IDX_W-1:0] rd_idx;
  logic [AW-1:0]    rd_addr;

  logic [COUNT_W-1:0] seg_cnt7;
  logic [COUNT_W-1:0] max7;
  logic [COUNT_W-1:0] count7;
  logic [IDX_W-1:0]   idx_inc;
  logic [PASS_W:0]    pass_inc;
  logic [TIME_W-1:0]  elapsed;
  action_t            act;
  logic               run;
  logic               status_run;

  // Configuration writes; register writes never touch the run state.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= '0;
      repeat_enable <= 1'b0;
      repeat_limit  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SEGMENT_COUNT: segment_count <= cfg.data[4:0];
        CFG_REPEAT_ENABLE: repeat_enable <= cfg.data[0];
        CFG_REPEAT_LIMIT:  repeat_limit  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Handshakes: the step stage moves when the output register is free or being drained.
  assign s1_adv    = s1_valid && (!out_valid || result.ready);
  assign cmd.ready = !s1_valid || s1_adv;
  assign accept    = cmd.valid && cmd.ready;

  // Durations are scaled to milliseconds on the way in.
  assign in_entry.on_ms  = {16'b0, cmd.on_minutes} * MS_PER_MINUTE;
  assign in_entry.off_ms = {16'b0, cmd.off_minutes} * MS_PER_MINUTE;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode     <= mode_t'(cmd.mode);
      s1_now      <= cmd.now_ms;
      s1_slot     <= cmd.slot;
      s1_wr_entry <= in_entry;
    end
  end

  // Table access: write from the step stage, read at the index the step leaves behind.
  assign slot8   = {4'b0, s1_slot};
  assign wr_en   = s1_adv && (s1_mode == MODE_WRITE) && (slot8 < 8'(MAX_SEGMENTS));
  assign rd_idx  = s1_adv ? cur_idx_next : cur_idx;
  assign rd_idx8 = {3'b0, rd_idx};
  assign rd_addr = rd_idx8[AW-1:0];

  oss_seg_mem #(
    .DEPTH (MAX_SEGMENTS),
    .AW    (AW)
  ) u_seg_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (slot8[AW-1:0]),
    .wr_data (s1_wr_entry),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (entry)
  );

  // Effective segment count.
  assign seg_cnt7 = {2'b0, segment_count};
  assign max7     = COUNT_W'(MAX_SEGMENTS);
  assign count7   = (seg_cnt7 > max7) ? max7 : seg_cnt7;

  assign idx_inc  = cur_idx + 5'd1;
  assign pass_inc = {1'b0, pass_cnt} + 9'd1;
  assign elapsed  = s1_now - start_ms;

  // Sequencer step for the item in the step stage.
  always_comb begin
    started_next  = started;
    cur_idx_next  = cur_idx;
    in_on_next    = in_on;
    start_ms_next = start_ms;
    pass_cnt_next = pass_cnt;
    act           = ACT_NONE;
    run           = 1'b1;
    case (s1_mode)
      MODE_RESTART: begin
        started_next  = 1'b0;
        cur_idx_next  = '0;
        in_on_next    = 1'b1;
        start_ms_next = s1_now;
        pass_cnt_next = '0;
      end
      MODE_TICK: begin
        if (count7 == '0) begin
          act = ACT_STOP;
          run = 1'b0;
        end else if (!started) begin
          started_next  = 1'b1;
          cur_idx_next  = '0;
          in_on_next    = 1'b1;
          start_ms_next = s1_now;
          pass_cnt_next = '0;
          act           = ACT_ON;
        end else if ({2'b0, cur_idx} >= count7) begin
          act = ACT_STOP;
          run = 1'b0;
        end else if (in_on && (entry.on_ms != '0) && (elapsed >= entry.on_ms)) begin
          in_on_next    = 1'b0;
          start_ms_next = s1_now;
          act           = ACT_OFF;
        end else if (!in_on && (entry.off_ms != '0) && (elapsed >= entry.off_ms)) begin
          // Segment done: advance, and at the end of the table stop or wrap.
          if ({2'b0, idx_inc} >= count7) begin
            if (!repeat_enable ||
                ((repeat_limit != '0) && (pass_inc >= {1'b0, repeat_limit}))) begin
              cur_idx_next = idx_inc;
              act          = ACT_STOP;
            end else begin
              if (repeat_limit != '0) begin
                pass_cnt_next = pass_inc[PASS_W-1:0];
              end
              cur_idx_next  = '0;
              in_on_next    = 1'b1;
              start_ms_next = s1_now;
              act           = ACT_ON;
            end
          end else begin
            cur_idx_next  = idx_inc;
            in_on_next    = 1'b1;
            start_ms_next = s1_now;
            act           = ACT_ON;
          end
        end
      end
      default: ;
    endcase
  end

  // Status after the step; ticks report their own running flag.
  assign status_run = started_next && ({2'b0, cur_idx_next} < count7);

  // Run state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      started  <= 1'b0;
      cur_idx  <= '0;
      in_on    <= 1'b1;
      start_ms <= '0;
      pass_cnt <= '0;
    end else if (s1_adv) begin
      started  <= started_next;
      cur_idx  <= cur_idx_next;
      in_on    <= in_on_next;
      start_ms <= start_ms_next;
      pass_cnt <= pass_cnt_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_action <= act;
      out_seg    <= status_run ? cur_idx_next[SEGNUM_W-1:0] : '0;
      out_run    <= (s1_mode == MODE_TICK) ? run : status_run;
    end
  end

  assign result.valid          = out_valid;
  assign result.action         = out_action;
  assign result.segment_number = out_seg;
  assign result.running        = out_run;

endmodule
